FILE: sv/edbc_pkg.sv
package edbc_pkg;

    typedef struct packed {
        logic [15:0] day_count;
        logic [7:0]  minute_in;
        logic [7:0]  hour_in;
    } t_in_s;

    typedef struct packed {
        logic       ok;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_off;
        logic [2:0] weekday;
    } t_date_s;

    // valid window: 2000-01-01 .. 2099-12-31 as days since 1970-01-01
    localparam logic [15:0] DAY_LO    = 16'd10957;
    localparam logic [15:0] DAY_HI    = 16'd47481;
    // 1996-03-01, start of the four-year block holding 2000-01-01
    localparam logic [15:0] DAY_BASE  = 16'd9556;
    localparam logic [15:0] DAYS_QUAD = 16'd1461;
    localparam logic [10:0] DAYS_YEAR = 11'd365;
    localparam logic [7:0]  HOUR_MAX  = 8'd23;
    localparam logic [7:0]  MIN_MAX   = 8'd59;

    // floor(t / 1461) = (t * RECIP_QUAD) >> QUAD_SHIFT for t < 2^16
    localparam logic [31:0] RECIP_QUAD = 32'd22967;
    localparam int          QUAD_SHIFT = 25;
    // floor(w / 7) = (w * RECIP_WEEK) >> WEEK_SHIFT for w < 2^17
    localparam logic [34:0] RECIP_WEEK = 35'd149797;
    localparam int          WEEK_SHIFT = 20;
    localparam logic [16:0] WEEK_DAYS  = 17'd7;
    localparam logic [16:0] EPOCH_WDAY = 17'd4;

    // first day of each March-based month within the year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    function automatic logic [3:0] month_idx(input logic [8:0] doy);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (doy >= MONTH_START[i]) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // two BCD digits of v < 100 (tens via x*205>>11)
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [17:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 18'(v) * 18'd205;
        tens = p[14:11];
        ones = v - 7'(7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

FILE: sv/epoch_day_to_bcd_calendar.sv
// Converts an hour, a minute and a count of days since 1970-01-01 into a
// real-time-clock register image in BCD (minute, hour, day, weekday with
// 0 = Sunday, month, two-digit year). The image is flagged ok in tuser only
// for hour <= 23, minute <= 59 and a date within 2000..2099; otherwise tuser
// is 0 and tdata is all zeros. One word is accepted per cycle while the
// pipeline is not stalled, and each word yields one result; the pipeline
// holds five words, with the longest paths being the reciprocal multiplies
// that split the day count into four-year blocks and into weeks.
// Backpressure on the output stalls only the stages that are full.
module epoch_day_to_bcd_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hour_in[7:0], minute_in[15:8], day_count[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // minute_bcd[6:0], hour_bcd[12:7], day_bcd[18:13],
                                        // weekday[21:19], month_bcd[26:22], year_bcd[34:27]
    output logic        m_axis_tuser    // ok
);
    import edbc_pkg::*;

    t_in_s   in_word;
    t_date_s date;
    logic    date_v;
    logic    date_rdy;

    assign in_word.hour_in   = s_axis_tdata[7:0];
    assign in_word.minute_in = s_axis_tdata[15:8];
    assign in_word.day_count = s_axis_tdata[31:16];

    edbc_civil u_civil (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (in_word),
        .o_valid (date_v),
        .i_ready (date_rdy),
        .o_date  (date)
    );

    edbc_bcd_out u_bcd_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (date_v),
        .o_ready       (date_rdy),
        .i_date        (date),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: sv/edbc_civil.sv
module edbc_civil (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  edbc_pkg::t_in_s i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output edbc_pkg::t_date_s o_date
);
    import edbc_pkg::*;

    // stage A: input word
    logic        r_a_v;
    t_in_s       r_a;
    // stage B: four-year block split
    logic        r_b_v;
    logic        r_b_ok;
    logic [5:0]  r_b_min;
    logic [4:0]  r_b_hour;
    logic [15:0] r_b_days;
    logic [4:0]  r_b_q;
    logic [15:0] r_b_t;
    // stage C: year in block, day of year, weekday quotient
    logic        r_c_v;
    logic        r_c_ok;
    logic [5:0]  r_c_min;
    logic [4:0]  r_c_hour;
    logic [4:0]  r_c_q;
    logic [1:0]  r_c_yoe;
    logic [8:0]  r_c_doy;
    logic [16:0] r_c_wsum;
    logic [13:0] r_c_wq;
    // stage D: finished date
    logic        r_d_v;
    t_date_s     r_d;

    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d   = !r_d_v || i_ready;
    assign rdy_c   = !r_c_v || rdy_d;
    assign rdy_b   = !r_b_v || rdy_c;
    assign rdy_a   = !r_a_v || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_d_v;
    assign o_date  = r_d;

    // stage A logic
    logic        n_b_ok;
    logic [15:0] n_b_t;
    logic [31:0] prod_q;

    always_comb begin
        n_b_ok = (r_a.hour_in <= HOUR_MAX) && (r_a.minute_in <= MIN_MAX)
                 && (r_a.day_count >= DAY_LO) && (r_a.day_count <= DAY_HI);
        n_b_t  = r_a.day_count - DAY_BASE;
        prod_q = 32'(n_b_t) * RECIP_QUAD;
    end

    // stage B logic
    logic [15:0] rem_q;
    logic [10:0] r11;
    logic [1:0]  n_c_yoe;
    logic [10:0] doy11;
    logic [16:0] n_c_wsum;
    logic [34:0] prod_w;

    always_comb begin
        rem_q = r_b_t - 16'(16'(r_b_q) * DAYS_QUAD);
        r11   = rem_q[10:0];
        if (r11 >= 11'd1095) begin
            n_c_yoe = 2'd3;
        end else if (r11 >= 11'd730) begin
            n_c_yoe = 2'd2;
        end else if (r11 >= DAYS_YEAR) begin
            n_c_yoe = 2'd1;
        end else begin
            n_c_yoe = 2'd0;
        end
        doy11    = r11 - 11'(11'(n_c_yoe) * DAYS_YEAR);
        n_c_wsum = 17'(r_b_days) + EPOCH_WDAY;
        prod_w   = 35'(n_c_wsum) * RECIP_WEEK;
    end

    // stage C logic
    logic [3:0]  mp;
    logic [8:0]  dday;
    logic [16:0] wrem;
    logic [7:0]  yoff8;
    t_date_s     n_d;

    always_comb begin
        mp   = month_idx(r_c_doy);
        dday = r_c_doy - MONTH_START[mp] + 9'd1;
        wrem = r_c_wsum - 17'(17'(r_c_wq) * WEEK_DAYS);
        yoff8 = 8'({r_c_q, 2'b00}) + 8'(r_c_yoe) + ((mp >= 4'd10) ? 8'd1 : 8'd0) - 8'd4;
        n_d.ok       = r_c_ok;
        n_d.minute   = r_c_min;
        n_d.hour     = r_c_hour;
        n_d.day      = dday[4:0];
        n_d.month    = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        n_d.year_off = yoff8[6:0];
        n_d.weekday  = wrem[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= i_valid;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
            if (rdy_d) r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a <= i_data;
        end
        if (rdy_b) begin
            r_b_ok   <= n_b_ok;
            r_b_min  <= r_a.minute_in[5:0];
            r_b_hour <= r_a.hour_in[4:0];
            r_b_days <= r_a.day_count;
            r_b_q    <= prod_q[QUAD_SHIFT+4:QUAD_SHIFT];
            r_b_t    <= n_b_t;
        end
        if (rdy_c) begin
            r_c_ok   <= r_b_ok;
            r_c_min  <= r_b_min;
            r_c_hour <= r_b_hour;
            r_c_q    <= r_b_q;
            r_c_yoe  <= n_c_yoe;
            r_c_doy  <= doy11[8:0];
            r_c_wsum <= n_c_wsum;
            r_c_wq   <= prod_w[WEEK_SHIFT+13:WEEK_SHIFT];
        end
        if (rdy_d) begin
            r_d <= n_d;
        end
    end

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v && r_d.ok |-> (r_d.month >= 4'd1) && (r_d.month <= 4'd12))
        else $error("month out of range");

    a_day_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v && r_d.ok |-> (r_d.day >= 5'd1) && (r_d.year_off <= 7'd99))
        else $error("day or year out of range");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v |-> r_d.weekday <= 3'd6)
        else $error("weekday out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v && !i_ready |=> r_d_v && $stable(r_d))
        else $error("date changed while stalled");

endmodule

FILE: sv/edbc_bcd_out.sv
module edbc_bcd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  edbc_pkg::t_date_s i_date,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,
    output logic              m_axis_tuser
);
    import edbc_pkg::*;

    logic        r_v;
    logic        r_ok;
    logic [39:0] r_data;
    logic [39:0] n_data;
    logic [7:0]  b_min, b_hour, b_day, b_mon, b_year;

    assign o_ready = !r_v || m_axis_tready;

    always_comb begin
        b_min  = bcd2(7'(i_date.minute));
        b_hour = bcd2(7'(i_date.hour));
        b_day  = bcd2(7'(i_date.day));
        b_mon  = bcd2(7'(i_date.month));
        b_year = bcd2(i_date.year_off);
        n_data = '0;
        if (i_date.ok) begin
            n_data[6:0]   = b_min[6:0];
            n_data[12:7]  = b_hour[5:0];
            n_data[18:13] = b_day[5:0];
            n_data[21:19] = i_date.weekday;
            n_data[26:22] = b_mon[4:0];
            n_data[34:27] = b_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ok   <= i_date.ok;
            r_data <= n_data;
        end
    end

    assign m_axis_tvalid = r_v;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_ok;

    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !r_ok |-> r_data == 40'd0)
        else $error("image not cleared on invalid word");

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_ok |-> (r_data[30:27] <= 4'd9) && (r_data[34:31] <= 4'd9)
                        && (r_data[3:0] <= 4'd9) && (r_data[6:4] <= 3'd5))
        else $error("bad BCD digit");

    a_hour_tens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_ok |-> (r_data[12:11] <= 2'd2) && (r_data[39:35] == 5'd0))
        else $error("bad hour or pad bits");

endmodule

FILE: sim/epoch_day_to_bcd_calendar_checker.sv
module epoch_day_to_bcd_calendar_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // hour_in[7:0], minute_in[15:8], day_count[31:16]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // minute_bcd[6:0], hour_bcd[12:7], day_bcd[18:13],
                                     // weekday[21:19], month_bcd[26:22], year_bcd[34:27]
    input  logic        i_m_tuser,   // ok
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_ok_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOUR_LAST  = 23;
    localparam int unsigned MINUTE_LAST = 59;
    localparam int unsigned YEAR_FIRST = 2000;
    localparam int unsigned YEAR_LAST  = 2099;

    typedef struct packed {
        logic       ok;
        logic [7:0] year_bcd;
        logic [4:0] month_bcd;
        logic [2:0] weekday;
        logic [5:0] day_bcd;
        logic [5:0] hour_bcd;
        logic [6:0] minute_bcd;
    } t_rtc_image;

    t_rtc_image expected_images[$];

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // days-to-civil on a March-based year, epoch shifted to 0000-03-01
    function automatic t_rtc_image civil_rtc_image(input logic [7:0] hr, input logic [7:0] mn,
                                                   input logic [15:0] days);
        t_rtc_image  img;
        int unsigned z, era, doe, yoe, doy, mp, d, m, y;
        img = '0;
        if (hr > HOUR_LAST || mn > MINUTE_LAST) begin
            return img;
        end
        z   = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
        if (y < YEAR_FIRST || y > YEAR_LAST) begin
            return img;
        end
        img.ok         = 1'b1;
        img.minute_bcd = 7'(to_bcd(mn));
        img.hour_bcd   = 6'(to_bcd(hr));
        img.day_bcd    = 6'(to_bcd(d));
        img.weekday    = 3'((days + 4) % 7);
        img.month_bcd  = 5'(to_bcd(m));
        img.year_bcd   = to_bcd(y - YEAR_FIRST);
        return img;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_rtc_image want;
        if (!i_rst_n) begin
            expected_images.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_ok_count   = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_images.push_back(civil_rtc_image(i_s_tdata[7:0], i_s_tdata[15:8],
                                                          i_s_tdata[31:16]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_images.size() == 0) begin
                    $error("unexpected output word 0x%0h, tuser %0b", i_m_tdata, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = expected_images.pop_front();
                    o_checked++;
                    if (want.ok) begin
                        o_ok_count++;
                    end
                    check_field("ok", want.ok, i_m_tuser);
                    check_field("minute_bcd", want.minute_bcd, i_m_tdata[6:0]);
                    check_field("hour_bcd", want.hour_bcd, i_m_tdata[12:7]);
                    check_field("day_bcd", want.day_bcd, i_m_tdata[18:13]);
                    check_field("weekday", want.weekday, i_m_tdata[21:19]);
                    check_field("month_bcd", want.month_bcd, i_m_tdata[26:22]);
                    check_field("year_bcd", want.year_bcd, i_m_tdata[34:27]);
                    check_field("tdata padding", 0, i_m_tdata[39:35]);
                end
            end
        end
        o_pending = expected_images.size();
    end

endmodule

FILE: sim/epoch_day_to_bcd_calendar_tb.sv
module epoch_day_to_bcd_calendar_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_WORDS = 1600;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned DAY_2000_JAN01 = 10957;
    localparam int unsigned DAY_2099_DEC31 = 47481;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    int          fail_count;
    int          pending;
    int          checked;
    int          ok_count;
    int          words_sent  = 0;
    int          cycle_count = 0;
    int          ready_left  = 0;
    t_ready_mode ready_mode  = READY_ALWAYS;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    epoch_day_to_bcd_calendar DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    epoch_day_to_bcd_calendar_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_ok_count   (ok_count)
    );

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 200);
        end
        ready_left--;
        case (ready_mode)
            READY_ALWAYS: begin
                m_axis_tready <= 1'b1;
            end
            READY_HALF: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            READY_SPARSE: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= (cycle_count % 5 != 0);
            end
        endcase
    end

    task automatic send_word(input logic [7:0] hr, input logic [7:0] mn,
                             input logic [15:0] days);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {days, mn, hr};
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // mostly well-formed times in the 2000..2099 window, some near its edges, some noise
    task automatic random_word(output logic [7:0] hr, output logic [7:0] mn,
                               output logic [15:0] days);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        hr   = 8'($urandom_range(0, 23));
        mn   = 8'($urandom_range(0, 59));
        if (pick < 70) begin
            days = 16'($urandom_range(DAY_2000_JAN01, DAY_2099_DEC31));
        end else if (pick < 80) begin
            days = pick[0] ? 16'($urandom_range(DAY_2000_JAN01 - 12, DAY_2000_JAN01 + 12))
                           : 16'($urandom_range(DAY_2099_DEC31 - 12, DAY_2099_DEC31 + 12));
        end else begin
            hr   = 8'($urandom);
            mn   = 8'($urandom);
            days = 16'($urandom);
        end
    endtask

    initial begin : stimulus
        logic [7:0]  hr;
        logic [7:0]  mn;
        logic [15:0] days;
        int          burst;
        int          sent_random;
        sent_random = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(8'd0,   8'd0,   16'd10957);
        send_word(8'd23,  8'd59,  16'd47481);
        send_word(8'd0,   8'd0,   16'd10956);
        send_word(8'd0,   8'd0,   16'd47482);
        send_word(8'd0,   8'd0,   16'd0);
        send_word(8'd255, 8'd255, 16'd65535);
        send_word(8'd24,  8'd0,   16'd20000);
        send_word(8'd0,   8'd60,  16'd20000);
        send_word(8'd23,  8'd60,  16'd20000);
        send_word(8'd255, 8'd0,   16'd11016);
        send_word(8'd0,   8'd255, 16'd11016);
        send_word(8'd12,  8'd30,  16'd11016);
        send_word(8'd12,  8'd30,  16'd11017);
        send_word(8'd9,   8'd9,   16'd12477);
        send_word(8'd1,   8'd1,   16'd11687);
        send_word(8'd10,  8'd10,  16'd47480);
        send_word(8'd18,  8'd45,  16'd65535);
        send_word(8'd23,  8'd59,  16'd32767);
        send_word(8'd7,   8'd7,   16'd32768);
        send_word(8'd0,   8'd59,  16'd16383);

        while (sent_random < RANDOM_WORDS) begin
            burst = $urandom_range(1, 48);
            for (int i = 0; i < burst && sent_random < RANDOM_WORDS; i++) begin
                random_word(hr, mn, days);
                send_word(hr, mn, days);
                sent_random++;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 8));
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d words, checked %0d results, %0d of them valid RTC images",
                 words_sent, checked, ok_count);
        $display("covered range edges, invalid times and random back-pressure modes");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
